@@ hw/rtl/fcache_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcache_pkg
// shared constants and types for the pinned-slot fifo cache manager
// ----------------------------------------------------------------------------
package fcache_pkg;

   localparam int CAPACITY_DEFAULT        = 32;
   localparam int USER_COUNT_BITS_DEFAULT = 8;

   localparam int ACTION_W     = 2;
   localparam int FILE_ID_W    = 32;
   localparam int SEGMENT_W    = 31;
   localparam int SLOT_FIELD_W = 5;
   localparam int STATUS_W     = 3;
   localparam int THRESH_W     = 5;
   localparam int KEY_W        = FILE_ID_W + SEGMENT_W;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 5'd30;

   localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CREATE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT   = 3'd0,
      ST_MISS  = 3'd1,
      ST_FREE  = 3'd2,
      ST_REUSE = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

endpackage
`default_nettype wire

@@ hw/rtl/fifo_cache_skip_pinned_slots.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_cache_skip_pinned_slots
// slot manager for a keyed cache, fifo replacement that skips pinned entries
// ----------------------------------------------------------------------------
// Requests (lookup, create, release) arrive on the req_ valid/ready channel;
// each produces exactly one rsp_ transfer carrying status and slot. The
// eviction threshold is written through csr_wr_en / csr_wr_data. The user
// must write it only while idle; the block itself does not enforce this.
// One request is worked on at a time by a sequencer around the key, user
// count and insertion order rams (one read and one write port each):
//   lookup           : key scan
//   release          : user count read, then decrement
//   create, new slot : key scan (+ order scan if no unpinned entry) + allocation
//   create, hit      : key scan + order search + order compaction
//   create, reuse    : key scan + pinned-skipping order scan + order compaction
//   create, full     : as for a new slot, with no free slot left
// The ram scans read one entry per cycle. req_ready is high only between requests.
// A finished result sits in the output register; the next request is taken
// while it waits, and the block holds its next result until rsp_ready frees
// that register. Reset empties the cache at once (valid bits in flops) and
// loads the threshold with 30; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_cache_skip_pinned_slots
   import fcache_pkg::*;
#(
   parameter int CAPACITY        = CAPACITY_DEFAULT,
   parameter int USER_COUNT_BITS = USER_COUNT_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [ACTION_W-1:0]     req_action,
   input  wire logic signed [FILE_ID_W-1:0] req_file_id,
   input  wire logic [SEGMENT_W-1:0]    req_segment_index,
   input  wire logic [SLOT_FIELD_W-1:0] req_release_slot,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [SLOT_FIELD_W-1:0]      rsp_slot,
   input  wire logic                    csr_wr_en,
   input  wire logic [THRESH_W-1:0]     csr_wr_data
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int UB     = USER_COUNT_BITS;
   localparam logic [UB-1:0]    USER_MAX = {UB{1'b1}};
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CAPACITY - 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_KSCAN = 8'b0000_0010,
      S_OFIND = 8'b0000_0100,
      S_OSCAN = 8'b0000_1000,
      S_SHIFT = 8'b0001_0000,
      S_ALLOC = 8'b0010_0000,
      S_REL   = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [THRESH_W-1:0] thr_ff, thr_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                s1_on_ff, s1_on_in;
   logic                s2_on_ff, s2_on_in;
   logic                free_on_ff, free_on_in;

   logic [ACTION_W-1:0]     act_ff, act_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [SLOT_W-1:0]       rs_ff, rs_in;
   logic [CNT_W-1:0]        iss_ff, iss_in;
   logic [SLOT_W-1:0]       s1_pos_ff, s1_pos_in;
   logic [SLOT_W-1:0]       s2_pos_ff, s2_pos_in;
   logic [SLOT_W-1:0]       s2_slot_ff, s2_slot_in;
   logic [SLOT_W-1:0]       wq_ff, wq_in;
   logic [SLOT_W-1:0]       tgt_ff, tgt_in;
   logic [SLOT_W-1:0]       free_ff, free_in;
   status_type              res_status_ff, res_status_in;
   logic [SLOT_W-1:0]       res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic              key_we;
   logic [SLOT_W-1:0] key_wa, key_ra;
   logic [KEY_W-1:0]  key_rd;
   logic              usr_we;
   logic [SLOT_W-1:0] usr_wa, usr_ra;
   logic [UB-1:0]     usr_wd, usr_rd;
   logic              ord_we;
   logic [SLOT_W-1:0] ord_wa, ord_wd, ord_ra, ord_rd;

   logic              rs_ok;
   logic [SLOT_W-1:0] iss_idx;
   logic [CNT_W-1:0]  count_last;

   fcache_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (key_ff),
      .rd_addr (key_ra),
      .rd_data (key_rd)
   );

   fcache_ram #(.WIDTH(UB), .DEPTH(CAPACITY)) u_user_ram (
      .clock   (clock),
      .wr_en   (usr_we),
      .wr_addr (usr_wa),
      .wr_data (usr_wd),
      .rd_addr (usr_ra),
      .rd_data (usr_rd)
   );

   fcache_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_wa),
      .wr_data (ord_wd),
      .rd_addr (ord_ra),
      .rd_data (ord_rd)
   );

   assign iss_idx    = iss_ff[SLOT_W-1:0];
   assign count_last = count_ff - CNT_W'(1);
   assign rs_ok      = (32'(req_release_slot) < CAPACITY) &&
                       valid_ff[SLOT_W'(req_release_slot)];

   always_comb begin
      state_in      = state_ff;
      thr_in        = thr_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      s1_on_in      = s1_on_ff;
      s2_on_in      = s2_on_ff;
      free_on_in    = free_on_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      rs_in         = rs_ff;
      iss_in        = iss_ff;
      s1_pos_in     = s1_pos_ff;
      s2_pos_in     = s2_pos_ff;
      s2_slot_in    = s2_slot_ff;
      wq_in         = wq_ff;
      tgt_in        = tgt_ff;
      free_in       = free_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      key_we = 1'b0;
      key_wa = '0;
      key_ra = '0;
      usr_we = 1'b0;
      usr_wa = '0;
      usr_wd = '0;
      usr_ra = '0;
      ord_we = 1'b0;
      ord_wa = '0;
      ord_wd = '0;
      ord_ra = '0;

      if (csr_wr_en) begin
         thr_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               key_in = {req_file_id, req_segment_index};
               rs_in  = SLOT_W'(req_release_slot);
               iss_in = '0;
               s1_on_in   = 1'b0;
               s2_on_in   = 1'b0;
               free_on_in = 1'b0;
               unique case (req_action) inside
                  ACT_LOOKUP, ACT_CREATE: begin
                     state_in = S_KSCAN;
                  end
                  ACT_RELEASE: begin
                     if (rs_ok) begin
                        usr_ra   = SLOT_W'(req_release_slot);
                        state_in = S_REL;
                     end else begin
                        res_status_in = ST_MISS;
                        res_slot_in   = '0;
                        state_in      = S_RESP;
                     end
                  end
                  default: begin
                     res_status_in = ST_MISS;
                     res_slot_in   = '0;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end

         S_KSCAN: begin
            // issue stage: one slot per cycle, note lowest free slot
            if (iss_ff < CAP_CNT) begin
               key_ra    = iss_idx;
               usr_ra    = iss_idx;
               s1_on_in  = 1'b1;
               s1_pos_in = iss_idx;
               iss_in    = iss_ff + CNT_W'(1);
               if (!free_on_ff && !valid_ff[iss_idx]) begin
                  free_on_in = 1'b1;
                  free_in    = iss_idx;
               end
            end else begin
               s1_on_in = 1'b0;
            end
            // compare stage
            if (s1_on_ff) begin
               if (valid_ff[s1_pos_ff] && key_rd == key_ff) begin
                  usr_we        = 1'b1;
                  usr_wa        = s1_pos_ff;
                  usr_wd        = (usr_rd == USER_MAX) ? usr_rd : usr_rd + UB'(1);
                  res_status_in = ST_HIT;
                  res_slot_in   = s1_pos_ff;
                  if (act_ff == ACT_CREATE) begin
                     tgt_in   = s1_pos_ff;
                     iss_in   = '0;
                     s1_on_in = 1'b0;
                     state_in = S_OFIND;
                  end else begin
                     state_in = S_RESP;
                  end
               end else if (CNT_W'(s1_pos_ff) == LAST_IDX) begin
                  iss_in   = '0;
                  s1_on_in = 1'b0;
                  s2_on_in = 1'b0;
                  if (act_ff != ACT_CREATE) begin
                     res_status_in = ST_MISS;
                     res_slot_in   = '0;
                     state_in      = S_RESP;
                  end else if (32'(count_ff) > 32'(thr_ff)) begin
                     state_in = S_OSCAN;
                  end else begin
                     state_in = S_ALLOC;
                  end
               end
            end
         end

         S_OFIND: begin
            if (iss_ff < count_ff) begin
               ord_ra    = iss_idx;
               s1_on_in  = 1'b1;
               s1_pos_in = iss_idx;
               iss_in    = iss_ff + CNT_W'(1);
            end else begin
               s1_on_in = 1'b0;
            end
            if (s1_on_ff) begin
               if (ord_rd == tgt_ff) begin
                  wq_in    = s1_pos_ff;
                  iss_in   = CNT_W'(s1_pos_ff) + CNT_W'(1);
                  s1_on_in = 1'b0;
                  state_in = S_SHIFT;
               end else if (CNT_W'(s1_pos_ff) == count_last) begin
                  state_in = S_RESP;
               end
            end
         end

         S_OSCAN: begin
            // order read, then user count read of that slot, then test
            if (iss_ff < count_ff) begin
               ord_ra    = iss_idx;
               s1_on_in  = 1'b1;
               s1_pos_in = iss_idx;
               iss_in    = iss_ff + CNT_W'(1);
            end else begin
               s1_on_in = 1'b0;
            end
            usr_ra     = ord_rd;
            s2_on_in   = s1_on_ff;
            s2_pos_in  = s1_pos_ff;
            s2_slot_in = ord_rd;
            if (s2_on_ff) begin
               if (usr_rd == '0) begin
                  key_we        = 1'b1;
                  key_wa        = s2_slot_ff;
                  usr_we        = 1'b1;
                  usr_wa        = s2_slot_ff;
                  usr_wd        = UB'(1);
                  tgt_in        = s2_slot_ff;
                  wq_in         = s2_pos_ff;
                  iss_in        = CNT_W'(s2_pos_ff) + CNT_W'(1);
                  s1_on_in      = 1'b0;
                  res_status_in = ST_REUSE;
                  res_slot_in   = s2_slot_ff;
                  state_in      = S_SHIFT;
               end else if (CNT_W'(s2_pos_ff) == count_last) begin
                  state_in = S_ALLOC;
               end
            end
         end

         S_SHIFT: begin
            // close the gap left by the removed entry, then append at the tail
            if (CNT_W'(wq_ff) == count_last) begin
               ord_we   = 1'b1;
               ord_wa   = wq_ff;
               ord_wd   = tgt_ff;
               state_in = S_RESP;
            end else begin
               if (iss_ff < count_ff) begin
                  ord_ra   = iss_idx;
                  s1_on_in = 1'b1;
                  iss_in   = iss_ff + CNT_W'(1);
               end else begin
                  s1_on_in = 1'b0;
               end
               if (s1_on_ff) begin
                  ord_we = 1'b1;
                  ord_wa = wq_ff;
                  ord_wd = ord_rd;
                  wq_in  = wq_ff + SLOT_W'(1);
               end
            end
         end

         S_ALLOC: begin
            if (free_on_ff) begin
               key_we            = 1'b1;
               key_wa            = free_ff;
               usr_we            = 1'b1;
               usr_wa            = free_ff;
               usr_wd            = UB'(1);
               ord_we            = 1'b1;
               ord_wa            = count_ff[SLOT_W-1:0];
               ord_wd            = free_ff;
               valid_in[free_ff] = 1'b1;
               count_in          = count_ff + CNT_W'(1);
               res_status_in     = ST_FREE;
               res_slot_in       = free_ff;
            end else begin
               res_status_in = ST_FULL;
               res_slot_in   = '0;
            end
            state_in = S_RESP;
         end

         S_REL: begin
            if (usr_rd != '0) begin
               usr_we        = 1'b1;
               usr_wa        = rs_ff;
               usr_wd        = usr_rd - UB'(1);
               res_status_in = ST_HIT;
               res_slot_in   = rs_ff;
            end else begin
               res_status_in = ST_MISS;
               res_slot_in   = '0;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = SLOT_FIELD_W'(res_slot_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THRESH_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         s1_on_ff     <= 1'b0;
         s2_on_ff     <= 1'b0;
         free_on_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_on_ff     <= s1_on_in;
         s2_on_ff     <= s2_on_in;
         free_on_ff   <= free_on_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_ff        <= key_in;
      rs_ff         <= rs_in;
      iss_ff        <= iss_in;
      s1_pos_ff     <= s1_pos_in;
      s2_pos_ff     <= s2_pos_in;
      s2_slot_ff    <= s2_slot_in;
      wq_ff         <= wq_in;
      tgt_ff        <= tgt_in;
      free_ff       <= free_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(valid_ff))
      else $error("entry count differs from number of valid slots");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_HIT || rsp_status == ST_MISS ||
                     rsp_status == ST_FREE || rsp_status == ST_REUSE ||
                     rsp_status == ST_FULL))
      else $error("undefined status code on result");

   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_MISS || rsp_status == ST_FULL)) |->
      (rsp_slot == '0))
      else $error("miss or full result with nonzero slot");

endmodule
`default_nettype wire

@@ hw/rtl/fcache_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcache_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fcache_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ verif/fifo_cache_skip_pinned_slots_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_cache_skip_pinned_slots_test
// self-checking bench for the pinned-slot fifo cache manager
// ----------------------------------------------------------------------------
// A clocked driver feeds lookup, create, release and unused-action requests from a queue
// that the stimulus process fills. A scoreboard model of the slot table,
// the user counts and the insertion order predicts status and slot for every
// accepted request. A clocked monitor checks each response against the
// oldest prediction. The run covers directed corner cases, then random
// traffic in fill, churn and drain bursts under several eviction thresholds,
// a user-count saturation burst, and random stalls on both channels.
// ----------------------------------------------------------------------------
module fifo_cache_skip_pinned_slots_test;
   import fcache_pkg::*;

   localparam int SLOTS = 32;
   localparam int USER_LIMIT = 255;
   localparam int POOL_SIZE = 48;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]     action;
      logic [KEY_W-1:0]        key;
      logic [SLOT_FIELD_W-1:0] release_slot;
   } cache_req_type;

   typedef struct packed {
      status_type              status;
      logic [SLOT_FIELD_W-1:0] slot;
   } cache_result_type;

   typedef enum int {MODE_FILL, MODE_CHURN, MODE_DRAIN} traffic_mode_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [ACTION_W-1:0]           req_action = '0;
   logic signed [FILE_ID_W-1:0]   req_file_id = '0;
   logic [SEGMENT_W-1:0]          req_segment_index = '0;
   logic [SLOT_FIELD_W-1:0]       req_release_slot = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [STATUS_W-1:0]           rsp_status;
   logic [SLOT_FIELD_W-1:0]       rsp_slot;
   logic                          csr_wr_en = 1'b0;
   logic [THRESH_W-1:0]           csr_wr_data = '0;

   // scoreboard copy of the cache
   logic [KEY_W-1:0]              model_key [SLOTS];
   logic                          model_valid [SLOTS];
   logic [7:0]                    model_users [SLOTS];
   logic [SLOT_FIELD_W-1:0]       model_order [SLOTS];
   int                            model_count;
   logic [THRESH_W-1:0]           model_threshold;

   cache_req_type                 pending_requests [$];
   cache_result_type              expected_results [$];
   cache_req_type                 queued_req;
   logic [KEY_W-1:0]              key_pool [POOL_SIZE];

   int                            sender_idle_pct = 21;
   int                            receiver_idle_pct = 81;
   int                            error_count = 0;
   int                            requests_accepted = 0;
   int                            results_checked = 0;
   int                            status_seen [5];
   int                            saturated_hits = 0;

   fifo_cache_skip_pinned_slots dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_file_id       (req_file_id),
      .req_segment_index (req_segment_index),
      .req_release_slot  (req_release_slot),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic int find_slot(input logic [KEY_W-1:0] key);
      for (int i = 0; i < SLOTS; i++) begin
         if (model_valid[i] && model_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic void order_drop(input int pos);
      for (int j = pos; j < model_count - 1; j++) model_order[j] = model_order[j + 1];
      model_count--;
   endfunction

   function automatic void order_push(input int s);
      if (model_count < SLOTS) begin
         model_order[model_count] = s[SLOT_FIELD_W-1:0];
         model_count++;
      end
   endfunction

   function automatic void bump_users(input int s);
      if (model_users[s] < USER_LIMIT) model_users[s]++;
      else saturated_hits++;
   endfunction

   function automatic void claim_slot(input int s, input logic [KEY_W-1:0] key);
      model_key[s] = key;
      model_valid[s] = 1'b1;
      model_users[s] = 8'd1;
      order_push(s);
   endfunction

   function automatic cache_result_type predict_cache_access(input cache_req_type rq);
      cache_result_type res;
      int s;
      int v;
      res.status = ST_MISS;
      res.slot = '0;
      s = find_slot(rq.key);
      case (rq.action)
         ACT_LOOKUP: begin
            if (s >= 0) begin
               bump_users(s);
               res.status = ST_HIT;
               res.slot = s[SLOT_FIELD_W-1:0];
            end
         end
         ACT_CREATE: begin
            if (s >= 0) begin
               bump_users(s);
               for (int p = 0; p < model_count; p++) begin
                  if (model_order[p] == s) begin
                     order_drop(p);
                     break;
                  end
               end
               order_push(s);
               res.status = ST_HIT;
               res.slot = s[SLOT_FIELD_W-1:0];
               return res;
            end
            if (model_count > model_threshold) begin
               for (int p = 0; p < model_count; p++) begin
                  v = model_order[p];
                  if (model_users[v] == 0) begin
                     order_drop(p);
                     claim_slot(v, rq.key);
                     res.status = ST_REUSE;
                     res.slot = v[SLOT_FIELD_W-1:0];
                     return res;
                  end
               end
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (!model_valid[i]) begin
                  claim_slot(i, rq.key);
                  res.status = ST_FREE;
                  res.slot = i[SLOT_FIELD_W-1:0];
                  return res;
               end
            end
            res.status = ST_FULL;
         end
         ACT_RELEASE: begin
            if (model_valid[rq.release_slot] && model_users[rq.release_slot] > 0) begin
               model_users[rq.release_slot]--;
               res.status = ST_HIT;
               res.slot = rq.release_slot;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_results.insert(expected_results.size(), predict_cache_access(
               '{req_action, {req_file_id, req_segment_index}, req_release_slot}));
            requests_accepted++;
         end
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            queued_req = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_action <= queued_req.action;
            req_file_id <= queued_req.key[KEY_W-1:SEGMENT_W];
            req_segment_index <= queued_req.key[SEGMENT_W-1:0];
            req_release_slot <= queued_req.release_slot;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at response %0d: %s got %0d, expected %0d",
               results_checked, what, got, want);
      error_count++;
   endtask

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transfer, status", rsp_status, -1);
            end else begin
               cache_result_type want;
               want = expected_results.pop_front();
               if (rsp_status != want.status) report_mismatch("status", rsp_status, want.status);
               if (rsp_slot != want.slot) report_mismatch("slot", rsp_slot, want.slot);
            end
            if (rsp_status < 5) status_seen[rsp_status]++;
            results_checked++;
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [KEY_W-1:0] fresh_key();
      return {32'($urandom()), 31'($urandom())};
   endfunction

   function automatic logic [SLOT_FIELD_W-1:0] any_slot();
      return SLOT_FIELD_W'($urandom_range(SLOTS - 1));
   endfunction

   task automatic queue_request(input logic [ACTION_W-1:0] action,
                                input logic [KEY_W-1:0] key,
                                input logic [SLOT_FIELD_W-1:0] rel);
      cache_req_type rq;
      rq = '{action, key, rel};
      while (pending_requests.size() >= 2) @(negedge clock);
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   task automatic wait_for_idle();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_threshold = value;
      @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      int idx;
      logic [KEY_W-1:0] k;
      r = $urandom_range(99);
      idx = $urandom_range(POOL_SIZE - 1);
      if (r < 65) return key_pool[idx];
      if (r < 75) return key_pool[idx] ^ (63'd1 << $urandom_range(KEY_W - 1));
      k = fresh_key();
      key_pool[idx] = k;
      return k;
   endfunction

   function automatic logic [SLOT_FIELD_W-1:0] pick_release_slot();
      int held [$];
      for (int i = 0; i < SLOTS; i++) begin
         if (model_valid[i] && model_users[i] > 0) held.insert(held.size(), i);
      end
      if (held.size() != 0 && $urandom_range(99) < 85)
         return SLOT_FIELD_W'(held[$urandom_range(held.size() - 1)]);
      return any_slot();
   endfunction

   task automatic run_random(input int total);
      int sent;
      int burst;
      int r;
      int create_pct;
      int lookup_pct;
      traffic_mode_type mode;
      sent = 0;
      while (sent < total) begin
         mode = traffic_mode_type'($urandom_range(2));
         case (mode)
            MODE_FILL: begin
               create_pct = 70;
               lookup_pct = 85;
            end
            MODE_CHURN: begin
               create_pct = 35;
               lookup_pct = 65;
            end
            default: begin
               create_pct = 15;
               lookup_pct = 30;
            end
         endcase
         burst = $urandom_range(15, 50);
         for (int n = 0; n < burst && sent < total; n++) begin
            @(negedge clock);
            r = $urandom_range(99);
            if (r < create_pct)
               queue_request(ACT_CREATE, pick_key(), any_slot());
            else if (r < lookup_pct)
               queue_request(ACT_LOOKUP, pick_key(), any_slot());
            else if (r < 95)
               queue_request(ACT_RELEASE, fresh_key(), pick_release_slot());
            else
               queue_request(ACT_UNUSED, fresh_key(), any_slot());
            sent++;
         end
         // now and then hold off the sender until all responses are back
         if ($urandom_range(3) == 0) wait_for_idle();
      end
   endtask

   // drive one slot's user count into saturation, then release a few
   task automatic run_saturation();
      logic [KEY_W-1:0] k;
      int s;
      wait_for_idle();
      s = -1;
      for (int i = 0; i < SLOTS && s < 0; i++) if (model_valid[i]) s = i;
      if (s >= 0) begin
         k = model_key[s];
      end else begin
         k = fresh_key();
         queue_request(ACT_CREATE, k, '0);
      end
      for (int n = 0; n < 265; n++) begin
         queue_request(($urandom_range(3) == 0) ? ACT_CREATE : ACT_LOOKUP, k, any_slot());
      end
      wait_for_idle();
      s = find_slot(k);
      if (s >= 0) repeat (3) queue_request(ACT_RELEASE, fresh_key(), s[SLOT_FIELD_W-1:0]);
   endtask

   initial begin
      logic [KEY_W-1:0] k_max;
      logic [KEY_W-1:0] k_min;
      logic [KEY_W-1:0] k_zero;
      logic [KEY_W-1:0] k_neg;
      k_max = {32'h7fff_ffff, 31'h7fff_ffff};
      k_min = {32'h8000_0000, 31'h0};
      k_zero = '0;
      k_neg = {32'hffff_ffff, 31'h7fff_ffff};
      for (int i = 0; i < SLOTS; i++) begin
         model_valid[i] = 1'b0;
         model_users[i] = '0;
         model_order[i] = '0;
         model_key[i] = '0;
      end
      for (int i = 0; i < 5; i++) status_seen[i] = 0;
      model_count = 0;
      model_threshold = THRESH_RESET;
      key_pool[0] = k_max;
      key_pool[1] = k_min;
      key_pool[2] = k_zero;
      key_pool[3] = k_neg;
      key_pool[4] = {32'h0000_0001, 31'h0};
      key_pool[5] = {32'h0, 31'h1};
      for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = fresh_key();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty cache, extremes of the key, refused releases
      queue_request(ACT_LOOKUP, k_max, '0);
      queue_request(ACT_RELEASE, k_zero, 5'd0);
      queue_request(ACT_RELEASE, k_zero, 5'd31);
      queue_request(ACT_UNUSED, k_neg, 5'd31);
      queue_request(ACT_CREATE, k_max, '0);
      queue_request(ACT_CREATE, k_min, '0);
      queue_request(ACT_CREATE, k_zero, '0);
      queue_request(ACT_CREATE, k_neg, '0);
      queue_request(ACT_CREATE, k_min, '0);
      queue_request(ACT_LOOKUP, k_max, '0);
      queue_request(ACT_LOOKUP, {32'h7fff_ffff, 31'h7fff_fffe}, '0);
      queue_request(ACT_LOOKUP, {32'hffff_ffff, 31'h7fff_ffff}, '0);
      queue_request(ACT_RELEASE, k_zero, 5'd0);
      queue_request(ACT_RELEASE, k_zero, 5'd0);
      queue_request(ACT_RELEASE, k_zero, 5'd0);
      queue_request(ACT_RELEASE, k_zero, 5'd2);
      wait_for_idle();

      // directed: reuse of unpinned entries, then fallback to a free slot
      write_threshold(5'd2);
      queue_request(ACT_CREATE, {32'h1234_5678, 31'h0abc_def0}, '0);
      queue_request(ACT_CREATE, {32'h8765_4321, 31'h7654_3210}, '0);
      queue_request(ACT_CREATE, {32'h0f0f_0f0f, 31'h70f0_f0f0}, '0);
      queue_request(ACT_LOOKUP, {32'h1234_5678, 31'h0abc_def0}, '0);
      queue_request(ACT_UNUSED, '1, 5'd31);
      wait_for_idle();

      write_threshold(5'd0);
      run_random(140);
      wait_for_idle();

      sender_idle_pct = 81;
      receiver_idle_pct = 21;
      write_threshold(5'd31);
      run_random(140);
      wait_for_idle();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_threshold(THRESH_W'($urandom_range(1, 30)));
      run_random(60);
      run_saturation();
      wait_for_idle();
      write_threshold(THRESH_W'($urandom_range(1, 8)));
      run_random(60);
      wait_for_idle();
      repeat (20) @(negedge clock);

      if (expected_results.size() != 0)
         report_mismatch("responses still owed", 0, expected_results.size());
      $display("covered %0d requests and %0d responses over thresholds 30, 2, 0, 31 and two random",
               requests_accepted, results_checked);
      $display("hit %0d, miss %0d, free %0d, reuse %0d, full %0d, saturated adds %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], saturated_hits);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
